// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define HFN_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define HFN_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HFN_ASSERT(lbl, clk, rstn, prop, msg)
`define HFN_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ----- hdl/hfn_pkg.sv -----
// ----------------------------------------------------------------------------
// hfn_pkg
// Constants and types for the heightmap face normal pipeline.
// ----------------------------------------------------------------------------
package hfn_pkg;

    localparam int MAX_COLUMNS_DEF = 256;

    localparam logic [12:0] ROW_COUNT_RESET    = 13'd256;
    localparam logic [8:0]  COLUMN_COUNT_RESET = 9'd256;
    localparam logic [12:0] ROW_COUNT_MIN      = 13'd2;
    localparam logic [12:0] ROW_COUNT_MAX      = 13'd4096;

    // register index, taken from paddr[2]
    localparam logic REG_ROW_COUNT    = 1'b0;
    localparam logic REG_COLUMN_COUNT = 1'b1;

    localparam int ITER_BITS = 15;   // result bits, one per stage
    localparam int S_W       = 34;   // dx^2 + dy^2 + 2^16
    localparam int P_W       = 52;   // odd * s
    localparam int E_W       = 68;   // remainder, signed
    localparam int R_SHIFT   = 30;   // (a*2^15)^2 = a^2 * 2^30
    localparam int Z_SHIFT   = 46;   // 256^2 * 2^30

    typedef logic        [S_W-1:0]       sum_t;
    typedef logic signed [P_W-1:0]       prod_t;
    typedef logic signed [E_W-1:0]       rem_t;
    typedef logic        [ITER_BITS-1:0] mag_t;

endpackage

// ----- hdl/heightmap_face_normals.sv -----
// ----------------------------------------------------------------------------
// heightmap_face_normals
// Streaming unit face normals of a Q8.8 heightmap, one line buffer deep.
// ----------------------------------------------------------------------------
// Samples enter row-major, one per cycle unless in_stall holds them, and a normal
// leaves for every quad once its lower-left sample arrives. Sustained rate is one
// sample per cycle while out_stall is low. A result passes through twenty register
// stages: line buffer read, differences, squares, sum, fifteen root-and-divide
// stages (one result bit each, all three components in parallel) and the
// output register. Empty stages close up under out_stall, so input keeps
// flowing while a result waits, until every stage is full.
`include "assert_macros.svh"

module heightmap_face_normals
    import hfn_pkg::*;
#(
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
    localparam int COL_W = $clog2(MAX_COLUMNS)
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [2:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic signed [15:0]      height,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [15:0]      normal_x,
    output logic signed [15:0]      normal_y,
    output logic [14:0]             normal_z,
    output logic [11:0]             quad_row,
    output logic [COL_W-1:0]        quad_column,
    output logic                    last_quad
);

    localparam int NST = 4 + ITER_BITS + 1;
    localparam int IT0 = 3;
    localparam int OST = NST - 1;
    localparam logic [12:0] MAXC = 13'(MAX_COLUMNS);

    typedef struct packed {
        logic [11:0]      row;
        logic [COL_W-1:0] col;
        logic             last;
    } meta_t;

    // configuration
    logic [12:0] row_count_reg;
    logic [8:0]  column_count_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg    <= ROW_COUNT_RESET;
            column_count_reg <= COLUMN_COUNT_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_ROW_COUNT:    row_count_reg    <= pwdata[12:0];
                REG_COLUMN_COUNT: column_count_reg <= pwdata[8:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_ROW_COUNT:    prdata = {19'd0, row_count_reg};
            REG_COLUMN_COUNT: prdata = {23'd0, column_count_reg};
            default:          prdata = '0;
        endcase
    end

    // position tracking
    logic [11:0]      row_position_reg, row_position_next;
    logic [COL_W-1:0] column_position_reg, column_position_next;
    logic [12:0]      rows, cols_full;
    logic [COL_W:0]   cols;
    logic [11:0]      r;
    logic [COL_W-1:0] c;
    logic [COL_W:0]   c_ext;
    logic             produce, acc;
    meta_t            meta_in;
    logic             en [NST];

    always_comb
    begin
        if (row_count_reg < ROW_COUNT_MIN)
            rows = ROW_COUNT_MIN;
        else if (row_count_reg > ROW_COUNT_MAX)
            rows = ROW_COUNT_MAX;
        else
            rows = row_count_reg;
        if ({4'd0, column_count_reg} < 13'd2)
            cols_full = 13'd2;
        else if ({4'd0, column_count_reg} > MAXC)
            cols_full = MAXC;
        else
            cols_full = {4'd0, column_count_reg};
        cols = cols_full[COL_W:0];

        r = ({1'b0, row_position_reg} >= rows) ? '0 : row_position_reg;
        c = ({1'b0, column_position_reg} >= cols) ? '0 : column_position_reg;
        c_ext = {1'b0, c};

        produce = (r != '0) && ((c_ext + 1'b1) < cols);
        meta_in.row  = r - 1'b1;
        meta_in.col  = c;
        meta_in.last = (({1'b0, r} + 13'd1) == rows) && ((c_ext + 2'd2) == cols);

        row_position_next    = r;
        column_position_next = c + 1'b1;
        if ((c_ext + 1'b1) >= cols)
        begin
            column_position_next = '0;
            row_position_next    = (({1'b0, r} + 13'd1) >= rows) ? '0 : r + 1'b1;
        end
    end

    assign acc      = in_valid && en[0];
    assign in_stall = !en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_position_reg    <= '0;
            column_position_reg <= '0;
        end
        else if (acc)
        begin
            row_position_reg    <= row_position_next;
            column_position_reg <= column_position_next;
        end
    end

    // line buffer, previous row
    logic signed [15:0] line_mem [MAX_COLUMNS];
    logic signed [15:0] a_h_reg, a_top_reg, a_right_reg;

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            line_mem[c] <= height;
            a_top_reg   <= line_mem[c];
            a_right_reg <= line_mem[c + 1'b1];
            a_h_reg     <= height;
        end
    end

    // stage control
    logic  vld_reg [NST];
    meta_t meta_reg [NST];
    logic [1:0] sgn_reg [1:NST-1];

    always_comb
    begin
        en[NST-1] = !vld_reg[NST-1] || !out_stall;
        for (int k = NST - 2; k >= 0; k--)
            en[k] = !vld_reg[k] || en[k+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NST; k++)
                vld_reg[k] <= 1'b0;
        end
        else
        begin
            if (en[0])
                vld_reg[0] <= in_valid && produce;
            for (int k = 1; k < NST; k++)
                if (en[k])
                    vld_reg[k] <= vld_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
            meta_reg[0] <= meta_in;
        for (int k = 1; k < NST; k++)
            if (en[k])
                meta_reg[k] <= meta_reg[k-1];
        for (int k = 2; k < NST; k++)
            if (en[k])
                sgn_reg[k] <= sgn_reg[k-1];
    end

    // differences and squares
    logic signed [16:0] b_dx_reg, b_dy_reg;
    sum_t               c_dx2_reg, c_dy2_reg;
    logic signed [33:0] dx_sq, dy_sq;

    assign dx_sq = b_dx_reg * b_dx_reg;
    assign dy_sq = b_dy_reg * b_dy_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            b_dx_reg   <= 17'(a_h_reg) - 17'(a_top_reg);
            b_dy_reg   <= 17'(a_right_reg) - 17'(a_top_reg);
            sgn_reg[1] <= {17'(a_right_reg) < 17'(a_top_reg), a_h_reg < a_top_reg};
        end
        if (en[2])
        begin
            c_dx2_reg <= sum_t'(dx_sq);
            c_dy2_reg <= sum_t'(dy_sq);
        end
    end

    // root and divide: largest q with (2q-1)^2 * s <= R, one bit per stage
    sum_t  it_s_reg [ITER_BITS+1];
    rem_t  it_e_reg [ITER_BITS+1][3];
    prod_t it_p_reg [ITER_BITS+1][3];
    mag_t  it_q_reg [ITER_BITS+1][3];

    sum_t  s0;
    rem_t  e0 [3];
    rem_t  e_nx [1:ITER_BITS][3];
    prod_t p_nx [1:ITER_BITS][3];
    mag_t  q_nx [1:ITER_BITS][3];

    always_comb
    begin
        s0 = c_dx2_reg + c_dy2_reg + sum_t'(65536);
        e0[0] = (rem_t'(c_dx2_reg) <<< R_SHIFT) - rem_t'(s0);
        e0[1] = (rem_t'(c_dy2_reg) <<< R_SHIFT) - rem_t'(s0);
        e0[2] = (rem_t'(1) <<< Z_SHIFT) - rem_t'(s0);
    end

    always_comb
    begin
        rem_t t;
        rem_t e_try;
        rem_t s_ext;
        rem_t p_ext;
        int   b;
        for (int j = 1; j <= ITER_BITS; j++)
        begin
            b = ITER_BITS - j;
            for (int ch = 0; ch < 3; ch++)
            begin
                s_ext = rem_t'(it_s_reg[j-1]);
                p_ext = rem_t'(it_p_reg[j-1][ch]);
                t     = (p_ext <<< (b + 2)) + (s_ext <<< (2 * b + 2));
                e_try = it_e_reg[j-1][ch] - t;
                e_nx[j][ch] = it_e_reg[j-1][ch];
                p_nx[j][ch] = it_p_reg[j-1][ch];
                q_nx[j][ch] = it_q_reg[j-1][ch];
                if (!e_try[E_W-1])
                begin
                    e_nx[j][ch] = e_try;
                    p_nx[j][ch] = it_p_reg[j-1][ch] + (prod_t'(it_s_reg[j-1]) <<< (b + 1));
                    q_nx[j][ch] = it_q_reg[j-1][ch] | (mag_t'(1) << b);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[IT0])
        begin
            it_s_reg[0] <= s0;
            for (int ch = 0; ch < 3; ch++)
            begin
                it_e_reg[0][ch] <= e0[ch];
                it_p_reg[0][ch] <= -prod_t'(s0);
                it_q_reg[0][ch] <= '0;
            end
        end
        for (int j = 1; j <= ITER_BITS; j++)
        begin
            if (en[IT0 + j])
            begin
                it_s_reg[j] <= it_s_reg[j-1];
                for (int ch = 0; ch < 3; ch++)
                begin
                    it_e_reg[j][ch] <= e_nx[j][ch];
                    it_p_reg[j][ch] <= p_nx[j][ch];
                    it_q_reg[j][ch] <= q_nx[j][ch];
                end
            end
        end
    end

    // output register
    logic signed [15:0] nx_reg, ny_reg;
    logic [14:0]        nz_reg;
    logic signed [15:0] qx, qy;

    assign qx = signed'({1'b0, it_q_reg[ITER_BITS][0]});
    assign qy = signed'({1'b0, it_q_reg[ITER_BITS][1]});

    always_ff @(posedge clk)
    begin
        if (en[OST])
        begin
            nx_reg <= sgn_reg[OST-1][0] ? qx : -qx;
            ny_reg <= sgn_reg[OST-1][1] ? qy : -qy;
            nz_reg <= it_q_reg[ITER_BITS][2];
        end
    end

    assign out_valid   = vld_reg[OST];
    assign normal_x    = nx_reg;
    assign normal_y    = ny_reg;
    assign normal_z    = nz_reg;
    assign quad_row    = meta_reg[OST].row;
    assign quad_column = meta_reg[OST].col;
    assign last_quad   = meta_reg[OST].last;

    `HFN_ASSERT(a_free_flow, clk, rst_n, !out_stall |-> !in_stall,
        "input stalled while output free")
    `HFN_ASSERT(a_nz_range, clk, rst_n,
        out_valid |-> (normal_z != 15'd0 && normal_z <= 15'd16384),
        "normal_z out of range")
    `HFN_ASSERT(a_nx_range, clk, rst_n,
        out_valid |-> (normal_x >= -16'sd16384 && normal_x <= 16'sd16384),
        "normal_x out of range")
    `HFN_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |-> !out_valid,
        "output valid in reset")

endmodule

// ----- tb/heightmap_face_normals_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heightmap_face_normals_tb
// Streams heightmap samples through the face normal block and compares every
// normal request against a bit-exact software copy of the line buffer,
// root-and-divide rounding and quad bookkeeping, under random idling on both
// channels and a range of grid sizes set over the APB port.
// ----------------------------------------------------------------------------
module heightmap_face_normals_tb;
    import hfn_pkg::*;

    typedef struct packed {
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic [14:0]        nz;
        logic [11:0]        qrow;
        logic [7:0]         qcol;
        logic               last;
    } normal_t;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid;
    logic               in_stall;
    logic signed [15:0] height;
    logic               out_valid;
    logic               out_stall;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic [14:0]        normal_z;
    logic [11:0]        quad_row;
    logic [7:0]         quad_column;
    logic               last_quad;

    heightmap_face_normals i_dut (.*);

    normal_t            normals_due[$];
    logic signed [15:0] line_buf [256];
    int unsigned        rows_reg;
    int unsigned        cols_reg;
    int unsigned        pos_r;
    int unsigned        pos_c;
    int                 errors;
    int                 samples_sent;
    int                 normals_seen;
    int                 send_idle;
    int                 recv_idle;
    int                 quiet_cycles;
    logic signed [15:0] last_h;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_idle);
    end

    // watchdog on cycles without any accepted request
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= 5000)
        begin
            $display("heightmap_face_normals test failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        normal_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            normals_seen <= normals_seen + 1;
            if (normals_due.size() == 0)
            begin
                $error("unexpected normal request");
                errors++;
            end
            else
            begin
                want = normals_due.pop_front();
                if (normal_x !== want.nx)
                begin
                    $error("normal_x expected %0d actual %0d", want.nx, normal_x);
                    errors++;
                end
                if (normal_y !== want.ny)
                begin
                    $error("normal_y expected %0d actual %0d", want.ny, normal_y);
                    errors++;
                end
                if (normal_z !== want.nz)
                begin
                    $error("normal_z expected %0d actual %0d", want.nz, normal_z);
                    errors++;
                end
                if (quad_row !== want.qrow)
                begin
                    $error("quad_row expected %0d actual %0d", want.qrow, quad_row);
                    errors++;
                end
                if (quad_column !== want.qcol)
                begin
                    $error("quad_column expected %0d actual %0d", want.qcol, quad_column);
                    errors++;
                end
                if (last_quad !== want.last)
                begin
                    $error("last_quad expected %0d actual %0d", want.last, last_quad);
                    errors++;
                end
            end
        end
    end

    function automatic int unsigned eff_rows();
        return (rows_reg < 2) ? 2 : (rows_reg > 4096) ? 4096 : rows_reg;
    endfunction

    function automatic int unsigned eff_cols();
        return (cols_reg < 2) ? 2 : (cols_reg > 256) ? 256 : cols_reg;
    endfunction

    // round(a * 2^14 / sqrt(s)), ties up, bit by bit
    function automatic logic [14:0] q14_ratio(longint unsigned a, longint unsigned s);
        longint unsigned rhs;
        longint unsigned odd;
        int unsigned     q;
        int unsigned     cand;
        rhs = a * 32768;
        rhs = rhs * rhs;
        q = 0;
        for (int b = 14; b >= 0; b--)
        begin
            cand = q | (1 << b);
            if (cand <= 16384)
            begin
                odd = 64'(2 * cand - 1);
                if (odd * odd * s <= rhs)
                    q = cand;
            end
        end
        return q[14:0];
    endfunction

    task automatic predict_normal(input logic signed [15:0] h);
        int unsigned     rows;
        int unsigned     cols;
        int              top;
        int              dx;
        int              dy;
        longint unsigned s;
        normal_t         n;
        rows = eff_rows();
        cols = eff_cols();
        if (pos_r >= rows)
            pos_r = 0;
        if (pos_c >= cols)
            pos_c = 0;
        if (pos_r >= 1 && pos_c + 1 < cols)
        begin
            top = int'(line_buf[pos_c]);
            dx = int'(h) - top;
            dy = int'(line_buf[pos_c + 1]) - top;
            s = longint'(dx) * dx + longint'(dy) * dy + 65536;
            n.nx = (dx < 0) ? 16'(q14_ratio(64'(-dx), s)) : -16'(q14_ratio(64'(dx), s));
            n.ny = (dy < 0) ? 16'(q14_ratio(64'(-dy), s)) : -16'(q14_ratio(64'(dy), s));
            n.nz = q14_ratio(64'd256, s);
            n.qrow = 12'(pos_r - 1);
            n.qcol = 8'(pos_c);
            n.last = (pos_r + 1 == rows) && (pos_c + 2 == cols);
            normals_due = {normals_due, n};
        end
        line_buf[pos_c] = h;
        pos_c++;
        if (pos_c >= cols)
        begin
            pos_c = 0;
            pos_r++;
            if (pos_r >= rows)
                pos_r = 0;
        end
    endtask

    task automatic send_sample(input logic signed [15:0] h);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        height   <= h;
        do
            @(posedge clk);
        while (in_stall);
        predict_normal(h);
        samples_sent++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (normals_due.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic apb_write(input logic reg_idx, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_idx == REG_ROW_COUNT)
            rows_reg = value & 32'h1FFF;
        else
            cols_reg = value & 32'h1FF;
    endtask

    task automatic apb_check(input logic reg_idx, input logic [31:0] want);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {reg_idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== want)
        begin
            $error("prdata expected %0d actual %0d", want, prdata);
            errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic signed [15:0] next_height();
        int mode;
        mode = $urandom_range(9);
        if (mode < 3)
            last_h = 16'($urandom());
        else if (mode < 9)
            last_h = last_h + $signed(16'($urandom_range(1024))) - 16'sd512;
        else
            last_h = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
        return last_h;
    endfunction

    task automatic set_grid(input logic [31:0] rows, input logic [31:0] cols);
        wait_idle();
        apb_write(REG_ROW_COUNT, rows);
        apb_write(REG_COLUMN_COUNT, cols);
    endtask

    task automatic test_register_reset();
        apb_check(REG_ROW_COUNT, 32'(ROW_COUNT_RESET));
        apb_check(REG_COLUMN_COUNT, 32'(COLUMN_COUNT_RESET));
        apb_write(REG_COLUMN_COUNT, 32'd511);
        apb_check(REG_COLUMN_COUNT, 32'd511);
    endtask

    task automatic test_extreme_heights();
        set_grid(32'd2, 32'd2);
        send_sample(16'sh8000);
        send_sample(16'sh7FFF);
        send_sample(16'sh7FFF);
        send_sample(16'sh0000);
        send_sample(16'sh0000);
        send_sample(16'sh8000);
        send_sample(16'sh8000);
        send_sample(16'sh8000);
        send_sample(16'sh5555);
        send_sample(16'shAAAA);
        send_sample(16'shAAAA);
        send_sample(16'sh5555);
    endtask

    // counts below and above range clamp
    task automatic test_clamped_counts();
        set_grid(32'd0, 32'd1);
        repeat (6) send_sample(next_height());
        set_grid(32'd8191, 32'd3);
        repeat (7) send_sample(next_height());
    endtask

    task automatic test_counts_mid_grid();
        set_grid(32'd4, 32'd6);
        repeat (9) send_sample(next_height());
        wait_idle();
        apb_write(REG_COLUMN_COUNT, 32'd2);
        repeat (4) send_sample(next_height());
        wait_idle();
        apb_write(REG_ROW_COUNT, 32'd2);
        repeat (5) send_sample(next_height());
    endtask

    task automatic test_random_grids(input int n, input int s_idle, input int r_idle);
        int          start;
        int unsigned rows;
        int unsigned cols;
        int unsigned k;
        int unsigned left;
        send_idle = s_idle;
        recv_idle = r_idle;
        start = samples_sent;
        while (samples_sent - start < n)
        begin
            if (pos_r == 0 && pos_c == 0)
            begin
                k = $urandom_range(99);
                if (k < 4)
                begin
                    rows = $urandom_range(3, 2);
                    cols = 256;
                end
                else if (k < 7)
                begin
                    rows = 4096;
                    cols = 2;
                end
                else if (k < 12)
                begin
                    rows = $urandom_range(1) ? $urandom_range(1) : $urandom_range(8191, 4097);
                    cols = $urandom_range(1) ? $urandom_range(1) : $urandom_range(511, 257);
                end
                else
                begin
                    rows = $urandom_range(6, 2);
                    cols = $urandom_range(12, 2);
                end
                set_grid(rows, cols);
            end
            else if (pos_r == 0)
                set_grid($urandom_range(6, 2), $urandom_range(12, 2));
            else
                set_grid($urandom_range(6, 2), $urandom_range(eff_cols(), 2));
            left = eff_rows() * eff_cols() - (pos_r * eff_cols() + pos_c);
            if (left > 300)
                left = 300;
            if ($urandom_range(99) < 15)
                left = $urandom_range(left, 1);
            if (left > unsigned'(n - (samples_sent - start)))
                left = unsigned'(n - (samples_sent - start));
            repeat (left) send_sample(next_height());
            if ($urandom_range(99) < 10)
                wait_idle();
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        in_valid     = 1'b0;
        height       = '0;
        out_stall    = 1'b0;
        errors       = 0;
        samples_sent = 0;
        normals_seen = 0;
        quiet_cycles = 0;
        send_idle    = 10;
        recv_idle    = 10;
        last_h       = '0;
        rows_reg     = 256;
        cols_reg     = 256;
        pos_r        = 0;
        pos_c        = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_register_reset();
        test_extreme_heights();
        test_clamped_counts();
        test_counts_mid_grid();
        test_random_grids(350, 7, 48);
        test_random_grids(350, 48, 7);
        test_random_grids(350, 0, 0);
        wait_idle();
        repeat (40) @(posedge clk);
        if (normals_due.size() != 0)
        begin
            $error("%0d normal requests never arrived", normals_due.size());
            errors++;
        end
        $display("Sent %0d height samples over many grid shapes, checked %0d normals",
                 samples_sent, normals_seen);
        $display("with clamped, mid-grid and extreme counts and idling on both sides.");
        if (errors == 0)
            $display("heightmap_face_normals test passed");
        else
            $display("heightmap_face_normals test failed");
        $finish;
    end

endmodule
